[rtl/core/nds_pkg.sv]
`timescale 1ns / 1ps

package nds_pkg;

    // Sizing of the token matcher, the stream offsets and the nesting counter
    localparam int MAX_TOKEN_BYTES = 4;
    localparam int OFFSET_BITS     = 16;
    localparam int DEPTH_BITS      = 8;

    // Window holds the newest MAX_TOKEN_BYTES bytes, newest in the low byte
    localparam int WIN_BITS = 8 * MAX_TOKEN_BYTES;
    // Holds 0..MAX_TOKEN_BYTES (byte counts and effective token lengths)
    localparam int CNT_BITS = $clog2(MAX_TOKEN_BYTES + 1);

    localparam int TOKEN_BITS = 32;
    localparam int LEN_BITS   = 3;
    localparam int TAG_BITS   = 8;
    localparam int CFG_BITS   = 32;
    localparam int INDEX_BITS = 3;

    localparam logic [OFFSET_BITS-1:0] OFS_MAX   = '1;
    localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX = '1;

    // Register indexes on the configuration port
    localparam logic [INDEX_BITS-1:0] REG_START_TOKEN  = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_START_LENGTH = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_END_TOKEN    = 3'd2;
    localparam logic [INDEX_BITS-1:0] REG_END_LENGTH   = 3'd3;
    localparam logic [INDEX_BITS-1:0] REG_REGION_TAG   = 3'd4;

    typedef enum logic [1:0] {
        KIND_PLAIN  = 2'd0,
        KIND_CLOSED = 2'd1,
        KIND_OPEN   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [TOKEN_BITS-1:0] start_token;
        logic [LEN_BITS-1:0]   start_length;
        logic [TOKEN_BITS-1:0] end_token;
        logic [LEN_BITS-1:0]   end_length;
        logic [TAG_BITS-1:0]   region_tag;
    } cfg_t;

    typedef struct packed {
        kind_t                  kind;
        logic [TAG_BITS-1:0]    tag;
        logic [OFFSET_BITS-1:0] begin_offset;
        logic [OFFSET_BITS-1:0] seg_length;
        logic                   end_of_text;
    } result_t;

    // Length register as used: zero reads as one, too large as the maximum
    function automatic logic [CNT_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] len);
        if (len == '0) begin
            return CNT_BITS'(1);
        end
        if (int'(len) > MAX_TOKEN_BYTES) begin
            return CNT_BITS'(MAX_TOKEN_BYTES);
        end
        return CNT_BITS'(len);
    endfunction

    // end_excl - beg, floored at zero and capped at the largest offset
    function automatic logic [OFFSET_BITS-1:0] clamp_len(
        input logic [OFFSET_BITS:0]   end_excl,
        input logic [OFFSET_BITS-1:0] beg
    );
        logic [OFFSET_BITS:0] diff;
        diff = end_excl - {1'b0, beg};
        if (end_excl <= {1'b0, beg}) begin
            return '0;
        end
        if (diff[OFFSET_BITS]) begin
            return OFS_MAX;
        end
        return diff[OFFSET_BITS-1:0];
    endfunction

endpackage

[rtl/core/nds_match.sv]
`timescale 1ns / 1ps

module nds_match
    import nds_pkg::*;
(
    input  logic [WIN_BITS-1:0]   window,
    input  logic [CNT_BITS-1:0]   count,
    input  logic [TOKEN_BITS-1:0] token,
    input  logic [CNT_BITS-1:0]   tok_len,
    output logic                  hit
);

    // Token byte i must sit tok_len-1-i bytes back from the newest byte
    always_comb
    begin
        logic [7:0]          tok_byte;
        logic [WIN_BITS-1:0] shifted;
        int                  back;
        hit = (count >= tok_len);
        for (int i = 0; i < MAX_TOKEN_BYTES; i++)
        begin
            tok_byte = 8'(token >> (8 * i));
            back     = int'(tok_len) - 1 - i;
            shifted  = window >> (8 * back);
            if (i < int'(tok_len) && tok_byte != shifted[7:0])
            begin
                hit = 1'b0;
            end
        end
    end

endmodule

[rtl/core/nds_seg.sv]
`timescale 1ns / 1ps

module nds_seg
    import nds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] text_byte,
    input  logic       is_last,
    input  cfg_t       cfg,
    output logic       emit,
    output result_t    result
);

    // previous bytes, newest in the low byte
    logic [WIN_BITS-9:0]    window_reg;
    logic [CNT_BITS-1:0]    since_tok_reg;
    logic [OFFSET_BITS-1:0] position_reg;
    logic [OFFSET_BITS-1:0] seg_start_reg;
    logic                   inside_reg;
    logic [DEPTH_BITS-1:0]  depth_reg;

    logic [WIN_BITS-1:0]    window_next;
    logic [CNT_BITS-1:0]    since_tok_next;
    logic [OFFSET_BITS-1:0] seg_start_next;
    logic                   inside_next;
    logic [DEPTH_BITS-1:0]  depth_next;

    logic [CNT_BITS-1:0]    count;
    logic [CNT_BITS-1:0]    start_eff;
    logic [CNT_BITS-1:0]    end_eff;
    logic [OFFSET_BITS:0]   after;
    logic [OFFSET_BITS-1:0] after_sat;
    logic                   hs;
    logic                   he;

    assign window_next = {window_reg, text_byte};
    assign count       = (int'(since_tok_reg) >= MAX_TOKEN_BYTES)
                         ? CNT_BITS'(MAX_TOKEN_BYTES)
                         : CNT_BITS'(since_tok_reg + 1'b1);
    assign start_eff   = eff_len(cfg.start_length);
    assign end_eff     = eff_len(cfg.end_length);
    assign after       = {1'b0, position_reg} + 1'b1;
    assign after_sat   = after[OFFSET_BITS] ? OFS_MAX : after[OFFSET_BITS-1:0];

    nds_match u_start_match (
        .window  (window_next),
        .count   (count),
        .token   (cfg.start_token),
        .tok_len (start_eff),
        .hit     (hs)
    );

    nds_match u_end_match (
        .window  (window_next),
        .count   (count),
        .token   (cfg.end_token),
        .tok_len (end_eff),
        .hit     (he)
    );

    always_comb
    begin
        emit                = 1'b0;
        result.kind         = KIND_PLAIN;
        result.tag          = '0;
        result.begin_offset = '0;
        result.seg_length   = '0;
        result.end_of_text  = is_last;
        inside_next         = inside_reg;
        depth_next          = depth_reg;
        seg_start_next      = seg_start_reg;
        since_tok_next      = count;

        if (!inside_reg)
        begin
            if (hs)
            begin
                result.seg_length = clamp_len(after - (OFFSET_BITS+1)'(start_eff),
                                              seg_start_reg);
                if (result.seg_length != '0)
                begin
                    emit                = 1'b1;
                    result.begin_offset = seg_start_reg;
                end
                inside_next    = 1'b1;
                depth_next     = '0;
                seg_start_next = after_sat;
                since_tok_next = '0;
            end
        end
        else if (depth_reg == '0 && he)
        begin
            result.seg_length = clamp_len(after - (OFFSET_BITS+1)'(end_eff), seg_start_reg);
            if (result.seg_length != '0)
            begin
                emit                = 1'b1;
                result.kind         = KIND_CLOSED;
                result.tag          = cfg.region_tag;
                result.begin_offset = seg_start_reg;
            end
            inside_next    = 1'b0;
            seg_start_next = after_sat;
            since_tok_next = '0;
        end
        else if (hs)
        begin
            if (depth_reg != DEPTH_MAX)
            begin
                depth_next = depth_reg + 1'b1;
            end
            since_tok_next = '0;
        end
        else if (he)
        begin
            depth_next     = depth_reg - 1'b1;
            since_tok_next = '0;
        end

        // flush whatever segment is still open on the final byte
        if (is_last && !emit)
        begin
            result.seg_length = clamp_len(after, seg_start_next);
            if (result.seg_length != '0)
            begin
                emit                = 1'b1;
                result.begin_offset = seg_start_next;
                if (inside_next)
                begin
                    result.kind = KIND_OPEN;
                    result.tag  = cfg.region_tag;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            since_tok_reg <= '0;
            position_reg  <= '0;
            seg_start_reg <= '0;
            inside_reg    <= 1'b0;
            depth_reg     <= '0;
        end
        else if (fire)
        begin
            if (is_last)
            begin
                window_reg    <= '0;
                since_tok_reg <= '0;
                position_reg  <= '0;
                seg_start_reg <= '0;
                inside_reg    <= 1'b0;
                depth_reg     <= '0;
            end
            else
            begin
                window_reg    <= window_next[WIN_BITS-9:0];
                since_tok_reg <= since_tok_next;
                position_reg  <= after_sat;
                seg_start_reg <= seg_start_next;
                inside_reg    <= inside_next;
                depth_reg     <= depth_next;
            end
        end
    end

endmodule

[rtl/core/nested_delimiter_segmenter.sv]
`timescale 1ns / 1ps
// A byte goes through one input register and one result register before its segment
//   (if any) is on the outputs; the token compare and counter update sit in one stage.
// Throughput: one byte per cycle while out_stall does not hold the result register.
// Reset (rst_n low, async): pipeline empty, stream state cleared, configuration
//   registers back to start '(' / end ')' with length 1 and region tag 1.
module nested_delimiter_segmenter
    import nds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // byte request channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             text_byte,
    input  logic                   is_last,
    // segment request channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             segment_kind,
    output logic [TAG_BITS-1:0]    tag,
    output logic [OFFSET_BITS-1:0] begin_offset,
    output logic [OFFSET_BITS-1:0] seg_length,
    output logic                   end_of_text,
    // configuration writes
    input  logic                   cfg_wr_en,
    input  logic [INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_data
);

    cfg_t       cfg_reg;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // result register
    logic       out_valid_reg;
    result_t    out_reg;

    logic       in_accept;
    logic       out_free;
    logic       fire;
    logic       emit;
    result_t    result;

    // The result register frees up whenever it is empty or being taken this cycle;
    // the input register moves on only then, so the stall is just this one stage deep.
    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_token  <= TOKEN_BITS'(40);
            cfg_reg.start_length <= LEN_BITS'(1);
            cfg_reg.end_token    <= TOKEN_BITS'(41);
            cfg_reg.end_length   <= LEN_BITS'(1);
            cfg_reg.region_tag   <= TAG_BITS'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_START_TOKEN:  cfg_reg.start_token  <= cfg_data[TOKEN_BITS-1:0];
                REG_START_LENGTH: cfg_reg.start_length <= cfg_data[LEN_BITS-1:0];
                REG_END_TOKEN:    cfg_reg.end_token    <= cfg_data[TOKEN_BITS-1:0];
                REG_END_LENGTH:   cfg_reg.end_length   <= cfg_data[LEN_BITS-1:0];
                REG_REGION_TAG:   cfg_reg.region_tag   <= cfg_data[TAG_BITS-1:0];
                default:          ; // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= text_byte;
            s1_last_reg <= is_last;
        end
    end

    nds_seg u_seg (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .text_byte (s1_byte_reg),
        .is_last   (s1_last_reg),
        .cfg       (cfg_reg),
        .emit      (emit),
        .result    (result)
    );

    // bytes that produce no segment leave the result register free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= emit;
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign segment_kind = out_reg.kind;
    assign tag          = out_reg.tag;
    assign begin_offset = out_reg.begin_offset;
    assign seg_length   = out_reg.seg_length;
    assign end_of_text  = out_reg.end_of_text;

endmodule

[rtl/core/nds_chk.sv]
`timescale 1ns / 1ps

module nds_chk
    import nds_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [1:0]             segment_kind,
    input logic [TAG_BITS-1:0]    tag,
    input logic [OFFSET_BITS-1:0] begin_offset,
    input logic [OFFSET_BITS-1:0] seg_length,
    input logic                   end_of_text
);

    // a stalled segment holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(segment_kind) && $stable(tag)
            && $stable(begin_offset) && $stable(seg_length) && $stable(end_of_text))
        else $error("stalled segment changed");

    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seg_length != '0)
        else $error("empty segment reported");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> segment_kind == KIND_PLAIN || segment_kind == KIND_CLOSED
            || segment_kind == KIND_OPEN)
        else $error("bad segment kind");

    a_plain_tag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && segment_kind == KIND_PLAIN |-> tag == '0)
        else $error("plain segment carries a tag");

    // an unterminated region can only show up at end of text
    a_open_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && segment_kind == KIND_OPEN |-> end_of_text)
        else $error("unterminated region before end of text");

endmodule

bind nested_delimiter_segmenter nds_chk u_nds_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .segment_kind (segment_kind),
    .tag          (tag),
    .begin_offset (begin_offset),
    .seg_length   (seg_length),
    .end_of_text  (end_of_text)
);
